FILE: design/slbd_pkg.sv
// shared types and constants of the scrolling level bar display
// holds the word structs, the mode and register codes and the reset values
// no dependencies
package slbd_pkg;

  // defaults for the top level parameters
  localparam int HISTORY_DEPTH_DEF    = 8;
  localparam int SAMPLES_PER_MEAN_DEF = 8;
  localparam int SAMPLE_BITS_DEF      = 12;

  // fixed field widths
  localparam int MODE_W    = 2;
  localparam int SAMPLE_W  = 12;
  localparam int FRAME_W   = 16;
  localparam int COL_W     = 3;
  localparam int LEVELS    = 8;
  localparam int STEP_W    = 9;
  localparam int PERIOD_W  = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 16;

  // register reset values
  localparam logic [STEP_W-1:0]   STEP_RESET   = 9'd70;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd25;

  // column bit of column zero within the high byte
  localparam logic [LEVELS-1:0] COL_BIT_FIRST = 8'h80;

  typedef enum logic [MODE_W-1:0] {
    MODE_SAMPLE  = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_REFRESH = 2'd2
  } slbd_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEVEL_STEP    = 1'b0,
    CFG_COMMIT_PERIOD = 1'b1
  } slbd_cfg_e;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SAMPLE_W-1:0] sample;
  } slbd_in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic [COL_W-1:0]   column;
  } slbd_out_t;

  // control shared by every history cell
  typedef struct packed {
    logic commit;
    logic shift;
  } slbd_cell_ctl_t;

endpackage

FILE: design/scrolling_level_bar_display_core.sv
// top level of the scrolling level bar display
// block averaging, commit timer, history chain, scan column and output staging
// depends on slbd_pkg, slbd_cell and slbd_level

// The block takes one input word per clock while input stall is low and answers a
// refresh word with one registered frame word; sample and tick words give no word back.
// An output register backed by a one-deep skid stage lets input words keep flowing
// while a frame waits downstream; input stall rises only once the skid stage holds a
// frame. The history is a row of cells that take a new block mean at the next free
// slot, or all move one place towards column zero once the row is full. Means are
// kept as undivided block sums and the level bounds are scaled to match, so no
// division appears; bound registers are reloaded when the level step is written.
module scrolling_level_bar_display_core #(
  parameter int HistoryDepth   = slbd_pkg::HISTORY_DEPTH_DEF,
  parameter int SamplesPerMean = slbd_pkg::SAMPLES_PER_MEAN_DEF,
  parameter int SampleBits     = slbd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [slbd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [slbd_pkg::CFG_W-1:0]     cfg_data_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  slbd_pkg::slbd_in_t             in_word_i,
  // frame words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output slbd_pkg::slbd_out_t            out_word_o
);
  import slbd_pkg::*;

  // sample bits that survive both the port width and the sample mask
  localparam int IN_W   = (SampleBits < SAMPLE_W) ? SampleBits : SAMPLE_W;
  localparam int SUM_W  = IN_W + $clog2(SamplesPerMean);
  localparam int CNT_W  = (SamplesPerMean > 1) ? $clog2(SamplesPerMean) : 1;
  localparam int FILL_W = $clog2(HistoryDepth + 1);
  localparam int IDX_W  = $clog2(HistoryDepth);
  // wide enough to hold the history depth itself for the column range check
  localparam int EXT_W  = (FILL_W > COL_W) ? FILL_W : COL_W;

  // handshake
  logic in_acc;

  // averaging
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [SUM_W-1:0] mean_q, mean_d;
  logic             ready_q, ready_d;
  logic [SUM_W-1:0] sum_add;

  // commit timer
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] tick_q, tick_d;
  logic [PERIOD_W-1:0] tick_inc;
  logic                due_q, due_d;

  // history
  logic [FILL_W-1:0]  fill_q, fill_d;
  logic               full;
  logic               commit;
  slbd_cell_ctl_t     cell_ctl;
  logic [SUM_W-1:0]   hist [HistoryDepth];

  // scan
  logic [COL_W-1:0]   col_q, col_d;
  logic [EXT_W-1:0]   col_ext;
  logic               col_shown;
  logic [SUM_W-1:0]   col_value;
  logic [LEVELS-1:0]  level;
  logic               res_valid;
  slbd_out_t          res;

  // output staging
  logic               out_valid_q, skid_valid_q;
  slbd_out_t          out_q, skid_q;
  logic               out_free;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;

  assign sum_add  = sum_q + SUM_W'(in_word_i.sample[IN_W-1:0]);
  assign tick_inc = tick_q + 1'b1;

  // per item state update
  always_comb begin
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    mean_d    = mean_q;
    ready_d   = ready_q;
    tick_d    = tick_q;
    due_d     = due_q;
    col_d     = col_q;
    res_valid = 1'b0;
    if (in_acc) begin
      case (slbd_mode_e'(in_word_i.mode))
        MODE_SAMPLE: begin
          if (cnt_q == CNT_W'(SamplesPerMean - 1)) begin
            // block complete: keep the whole sum as the mean
            mean_d  = sum_add;
            ready_d = 1'b1;
            sum_d   = '0;
            cnt_d   = '0;
          end else begin
            sum_d = sum_add;
            cnt_d = cnt_q + 1'b1;
          end
        end
        MODE_TICK: begin
          if (tick_inc == period_q) begin
            tick_d = '0;
            due_d  = 1'b1;
          end else begin
            tick_d = tick_inc;
          end
        end
        MODE_REFRESH: begin
          col_d     = col_q + 1'b1;
          res_valid = 1'b1;
        end
        default: begin
          // unused mode, nothing changes
        end
      endcase
    end
  end

  // a ready mean meets a raised flag: both drop and the mean enters the history
  assign commit = in_acc && ready_d && due_d;
  assign full   = (fill_q == FILL_W'(HistoryDepth));

  always_comb begin
    fill_d = fill_q;
    if (commit && !full) begin
      fill_d = fill_q + 1'b1;
    end
  end

  assign cell_ctl.commit = commit;
  assign cell_ctl.shift  = full;

  // row of history cells, column zero first; the last cell takes the new mean on a shift
  for (genvar i = 0; i < HistoryDepth; i++) begin : g_cell
    logic [SUM_W-1:0] nbr;
    if (i == HistoryDepth - 1) begin : g_last
      assign nbr = mean_d;
    end else begin : g_inner
      assign nbr = hist[i + 1];
    end

    slbd_cell #(
      .ValueW (SUM_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (cell_ctl),
      .load_i  (fill_q == FILL_W'(i)),
      .new_i   (mean_d),
      .nbr_i   (nbr),
      .value_o (hist[i])
    );
  end

  // column read sees the history as it stood before this word's commit
  assign col_ext   = EXT_W'(col_d);
  assign col_shown = (col_ext < EXT_W'(HistoryDepth));
  assign col_value = col_shown ? hist[col_ext[IDX_W-1:0]] : '0;

  slbd_level #(
    .SamplesPerMean (SamplesPerMean),
    .ValueW         (SUM_W)
  ) u_level (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_we_i (cfg_we_i && (slbd_cfg_e'(cfg_idx_i) == CFG_LEVEL_STEP)),
    .step_i    (cfg_data_i[STEP_W-1:0]),
    .value_i   (col_value),
    .level_o   (level)
  );

  assign res.frame  = {COL_BIT_FIRST >> col_d, level};
  assign res.column = col_d;

  // output register is free when empty or being taken this cycle
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q        <= '0;
      cnt_q        <= '0;
      mean_q       <= '0;
      ready_q      <= 1'b0;
      tick_q       <= '0;
      due_q        <= 1'b0;
      fill_q       <= '0;
      col_q        <= '0;
      period_q     <= PERIOD_RESET;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      mean_q  <= mean_d;
      ready_q <= ready_d && !commit;
      tick_q  <= tick_d;
      due_q   <= due_d && !commit;
      fill_q  <= fill_d;
      col_q   <= col_d;
      if (cfg_we_i && (slbd_cfg_e'(cfg_idx_i) == CFG_COMMIT_PERIOD)) begin
        period_q <= cfg_data_i[PERIOD_W-1:0];
      end
      if (out_free) begin
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= res_valid;
        end
      end else if (res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // frame payloads, no reset needed
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: design/slbd_cell.sv
// one history cell of the scrolling level bar display
// holds one block sum, loads a new one or takes its right neighbour's on a commit
// depends on slbd_pkg
module slbd_cell #(
  parameter int ValueW = 15
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  slbd_pkg::slbd_cell_ctl_t ctl_i,
  input  logic                    load_i,
  input  logic [ValueW-1:0]       new_i,
  input  logic [ValueW-1:0]       nbr_i,
  output logic [ValueW-1:0]       value_o
);
  import slbd_pkg::*;

  logic [ValueW-1:0] value_q, value_d;

  always_comb begin
    value_d = value_q;
    if (ctl_i.commit) begin
      if (ctl_i.shift) begin
        value_d = nbr_i;
      end else if (load_i) begin
        value_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else begin
      value_q <= value_d;
    end
  end

  assign value_o = value_q;

endmodule

FILE: design/slbd_level.sv
// level decoder of the scrolling level bar display
// keeps the level bounds scaled to block sums and turns a sum into a one-hot level
// depends on slbd_pkg
module slbd_level #(
  parameter int SamplesPerMean = 8,
  parameter int ValueW         = 15
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_we_i,
  input  logic [slbd_pkg::STEP_W-1:0]   step_i,
  input  logic [ValueW-1:0]             value_i,
  output logic [slbd_pkg::LEVELS-1:0]   level_o
);
  import slbd_pkg::*;

  // 8 * 511 * n + n stays below n * 4096
  localparam int BOUND_W = 13 + $clog2(SamplesPerMean);

  logic [BOUND_W-1:0] value_ext;
  logic [BOUND_W-1:0] step_ext;

  assign value_ext = BOUND_W'(value_i);
  assign step_ext  = BOUND_W'(step_i);

  // mean > k*step  <=>  sum >= n*k*step + n
  // mean < (k+1)*step  <=>  sum < n*(k+1)*step
  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    logic [BOUND_W-1:0] lo_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lo_q <= BOUND_W'(SamplesPerMean * k * int'(STEP_RESET) + SamplesPerMean);
      end else if (step_we_i) begin
        lo_q <= step_ext * BOUND_W'(SamplesPerMean * k) + BOUND_W'(SamplesPerMean);
      end
    end

    if (k == LEVELS - 1) begin : g_top
      // top level is open above
      assign level_o[k] = (value_ext >= lo_q);
    end else begin : g_mid
      logic [BOUND_W-1:0] hi_q;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          hi_q <= BOUND_W'(SamplesPerMean * (k + 1) * int'(STEP_RESET));
        end else if (step_we_i) begin
          hi_q <= step_ext * BOUND_W'(SamplesPerMean * (k + 1));
        end
      end

      assign level_o[k] = (value_ext >= lo_q) && (value_ext < hi_q);
    end
  end

endmodule
